@@ src/msds_pkg.sv @@
// ----------------------------------------------------------------------------
// msds_pkg
// Shared types and constants of the servo dispense sequencer.
// ----------------------------------------------------------------------------
package msds_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS - 1);

    localparam int ELAPSED_W = 17;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_ENGAGE_WAIT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_WAIT      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_WAIT      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ENGAGE_PULSE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DISPENSE_PULSE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SERVO_MAP      = 3'd5;

    localparam logic [15:0] ENGAGE_WAIT_RST    = 16'd1000;
    localparam logic [15:0] HALF_WAIT_RST      = 16'd2000;
    localparam logic [15:0] FULL_WAIT_RST      = 16'd6000;
    localparam logic [15:0] ENGAGE_PULSE_RST   = 16'd1000;
    localparam logic [15:0] DISPENSE_PULSE_RST = 16'd2000;
    localparam logic [31:0] SERVO_MAP_RST      = 32'h7654_3210;

    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_ACTIVATE = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ENGAGE = 2'd1,
        PH_HALF   = 2'd2,
        PH_FULL   = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic                   dose_full;
        logic [ELAPSED_W-1:0]   elapsed;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [15:0] engage_wait;
        logic [15:0] half_wait;
        logic [15:0] full_wait;
        logic [15:0] engage_pulse;
        logic [15:0] dispense_pulse;
        logic [31:0] servo_map;
    } cfg_t;

endpackage

@@ src/multi_channel_servo_dispense_sequencer.sv @@
// ----------------------------------------------------------------------------
// multi_channel_servo_dispense_sequencer
// Eight timed dispenser channels driven by activate and millisecond tick items.
//
// The input channel carries cmd, channel_index and full_dose. An activate
// transfer puts one channel into the engage phase and returns no result. A
// tick transfer walks the channels from zero upward. Each busy channel is
// read from the channel memory, updated and written back, and gives one
// result transfer with its servo number and pulse width; last marks the
// final result of the tick. A tick with every channel idle gives no result.
// A busy channel passes a scan step (memory read), then an update step; an
// idle channel below the last busy one takes a scan step only, and the walk
// ends after the last busy channel. The first result passes the scan state,
// the memory read and the output register. Input stall stays high until the
// walk is done.
// Results leave through an output register; when the receiver stalls, the
// walk waits on the busy channel until that register is free again.
// Configuration writes take effect at once and are meant for idle periods.
// Reset returns every channel to idle and the registers to their defaults.
// ----------------------------------------------------------------------------
module multi_channel_servo_dispense_sequencer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 cmd,
    input  logic [2:0]                           channel_index,
    input  logic                                 full_dose,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [3:0]                           servo_number,
    output logic [15:0]                          pulse_us,
    output logic                                 last,
    input  logic                                 cfg_write,
    input  logic [msds_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [msds_pkg::CFG_DATA_W-1:0]      cfg_data
);

    msds_pkg::cfg_t                     cfg;
    logic                               ram_wr_en;
    logic [msds_pkg::CH_W-1:0]          ram_wr_addr;
    logic [msds_pkg::ENTRY_W-1:0]       ram_wr_data;
    logic                               ram_rd_en;
    logic [msds_pkg::CH_W-1:0]          ram_rd_addr;
    logic [msds_pkg::ENTRY_W-1:0]       ram_rd_data;

    msds_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msds_ram #(
        .WIDTH (msds_pkg::ENTRY_W),
        .DEPTH (msds_pkg::NUM_CHANNELS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    msds_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .channel_index (channel_index),
        .full_dose     (full_dose),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .servo_number  (servo_number),
        .pulse_us      (pulse_us),
        .last          (last),
        .cfg           (cfg),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data),
        .ram_rd_en     (ram_rd_en),
        .ram_rd_addr   (ram_rd_addr),
        .ram_rd_data   (ram_rd_data)
    );

endmodule

@@ src/msds_ram.sv @@
// ----------------------------------------------------------------------------
// msds_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module msds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/msds_cfg.sv @@
// ----------------------------------------------------------------------------
// msds_cfg
// Configuration register file of the servo dispense sequencer.
// ----------------------------------------------------------------------------
module msds_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [msds_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [msds_pkg::CFG_DATA_W-1:0]      cfg_data,
    output msds_pkg::cfg_t                       cfg
);

    msds_pkg::cfg_t cfg_reg;
    msds_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                msds_pkg::REG_ENGAGE_WAIT:    cfg_next.engage_wait    = cfg_data[15:0];
                msds_pkg::REG_HALF_WAIT:      cfg_next.half_wait      = cfg_data[15:0];
                msds_pkg::REG_FULL_WAIT:      cfg_next.full_wait      = cfg_data[15:0];
                msds_pkg::REG_ENGAGE_PULSE:   cfg_next.engage_pulse   = cfg_data[15:0];
                msds_pkg::REG_DISPENSE_PULSE: cfg_next.dispense_pulse = cfg_data[15:0];
                msds_pkg::REG_SERVO_MAP:      cfg_next.servo_map      = cfg_data[31:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.engage_wait    <= msds_pkg::ENGAGE_WAIT_RST;
            cfg_reg.half_wait      <= msds_pkg::HALF_WAIT_RST;
            cfg_reg.full_wait      <= msds_pkg::FULL_WAIT_RST;
            cfg_reg.engage_pulse   <= msds_pkg::ENGAGE_PULSE_RST;
            cfg_reg.dispense_pulse <= msds_pkg::DISPENSE_PULSE_RST;
            cfg_reg.servo_map      <= msds_pkg::SERVO_MAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/msds_upd.sv @@
// ----------------------------------------------------------------------------
// msds_upd
// One-millisecond update of a single channel entry and its pulse width.
// ----------------------------------------------------------------------------
module msds_upd (
    input  msds_pkg::entry_t cur,
    input  msds_pkg::cfg_t   cfg,
    output msds_pkg::entry_t nxt,
    output logic [15:0]      pulse
);

    logic [msds_pkg::ELAPSED_W-1:0] elapsed_inc;
    logic [15:0]                    limit;

    always_comb
    begin
        if (cur.elapsed == msds_pkg::ELAPSED_MAX)
        begin
            elapsed_inc = cur.elapsed;
        end
        else
        begin
            elapsed_inc = cur.elapsed + 1'b1;
        end

        case (cur.phase)
            msds_pkg::PH_ENGAGE: limit = cfg.engage_wait;
            msds_pkg::PH_HALF:   limit = cfg.half_wait;
            default:             limit = cfg.full_wait;
        endcase

        if (cur.phase == msds_pkg::PH_ENGAGE)
        begin
            pulse = cfg.engage_pulse;
        end
        else
        begin
            pulse = cfg.dispense_pulse;
        end

        nxt         = cur;
        nxt.elapsed = elapsed_inc;
        if (elapsed_inc > {1'b0, limit})
        begin
            nxt.elapsed = '0;
            if (cur.phase == msds_pkg::PH_ENGAGE)
            begin
                nxt.phase     = cur.dose_full ? msds_pkg::PH_FULL : msds_pkg::PH_HALF;
                nxt.dose_full = 1'b0;
            end
            else
            begin
                nxt.phase = msds_pkg::PH_IDLE;
            end
        end
    end

endmodule

@@ src/msds_ctrl.sv @@
// ----------------------------------------------------------------------------
// msds_ctrl
// Sequencer that applies activations and walks the channel memory on ticks.
// ----------------------------------------------------------------------------
module msds_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic [2:0]                        channel_index,
    input  logic                              full_dose,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [3:0]                        servo_number,
    output logic [15:0]                       pulse_us,
    output logic                              last,
    input  msds_pkg::cfg_t                    cfg,
    output logic                              ram_wr_en,
    output logic [msds_pkg::CH_W-1:0]         ram_wr_addr,
    output logic [msds_pkg::ENTRY_W-1:0]      ram_wr_data,
    output logic                              ram_rd_en,
    output logic [msds_pkg::CH_W-1:0]         ram_rd_addr,
    input  logic [msds_pkg::ENTRY_W-1:0]      ram_rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PROC
    } state_t;

    state_t                             state_reg, state_next;
    logic [msds_pkg::CH_W-1:0]          ch_reg, ch_next;
    logic [msds_pkg::NUM_CHANNELS-1:0]  active_reg, active_next;
    logic                               out_valid_reg, out_valid_next;
    logic [3:0]                         servo_reg, servo_next;
    logic [15:0]                        pulse_reg, pulse_next;
    logic                               last_reg, last_next;

    logic                               accept;
    logic                               activate;
    logic                               fire;
    logic                               none_above;
    logic [2:0]                         map_slot;
    msds_pkg::entry_t                   cur_entry;
    msds_pkg::entry_t                   upd_entry;
    msds_pkg::entry_t                   act_entry;
    logic [15:0]                        upd_pulse;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign activate  = accept && (cmd == msds_pkg::CMD_ACTIVATE)
                       && (int'(channel_index) < msds_pkg::NUM_CHANNELS);
    assign cur_entry = msds_pkg::entry_t'(ram_rd_data);
    assign fire      = (state_reg == S_PROC) && (!out_valid_reg || !out_stall);
    assign map_slot  = 3'(ch_reg);

    msds_upd u_upd (
        .cur   (cur_entry),
        .cfg   (cfg),
        .nxt   (upd_entry),
        .pulse (upd_pulse)
    );

    always_comb
    begin
        none_above = 1'b1;
        for (int j = 0; j < msds_pkg::NUM_CHANNELS; j++)
        begin
            if ((j > int'(ch_reg)) && active_reg[j])
            begin
                none_above = 1'b0;
            end
        end
    end

    always_comb
    begin
        act_entry.phase     = msds_pkg::PH_ENGAGE;
        act_entry.dose_full = full_dose;
        act_entry.elapsed   = '0;

        ram_rd_en   = (state_reg == S_SCAN) && active_reg[ch_reg];
        ram_rd_addr = ch_reg;
        if (state_reg == S_PROC)
        begin
            ram_wr_en   = fire;
            ram_wr_addr = ch_reg;
            ram_wr_data = upd_entry;
        end
        else
        begin
            ram_wr_en   = activate;
            ram_wr_addr = msds_pkg::CH_W'(channel_index);
            ram_wr_data = act_entry;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg && out_stall;
        servo_next     = servo_reg;
        pulse_next     = pulse_reg;
        last_next      = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (activate)
                begin
                    active_next[msds_pkg::CH_W'(channel_index)] = 1'b1;
                end
                else if (accept && (cmd == msds_pkg::CMD_TICK) && (active_reg != '0))
                begin
                    ch_next    = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (active_reg[ch_reg])
                begin
                    state_next = S_PROC;
                end
                else if (ch_reg == msds_pkg::CH_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            S_PROC:
            begin
                if (fire)
                begin
                    out_valid_next      = 1'b1;
                    servo_next          = cfg.servo_map[{map_slot, 2'b00} +: 4];
                    pulse_next          = upd_pulse;
                    last_next           = none_above;
                    active_next[ch_reg] = (upd_entry.phase != msds_pkg::PH_IDLE);
                    if (none_above || (ch_reg == msds_pkg::CH_LAST))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
            servo_reg     <= '0;
            pulse_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            servo_reg     <= servo_next;
            pulse_reg     <= pulse_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign servo_number = servo_reg;
    assign pulse_us     = pulse_reg;
    assign last         = last_reg;

endmodule

@@ sim/msds_checker.sv @@
// ----------------------------------------------------------------------------
// msds_checker
// Watches the command, result and register ports of the dispense sequencer.
// It keeps its own copy of every channel's phase, dose choice and elapsed
// time, and of the registers. From this copy it works out the pulse commands
// that each tick must produce, and it compares each result transfer, field by
// field, with the oldest command still waiting. It reports the number of
// failures, the number of commands still waiting and the number checked.
// ----------------------------------------------------------------------------
module msds_checker
    import msds_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   cmd,
    input  logic [2:0]             channel_index,
    input  logic                   full_dose,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [3:0]             servo_number,
    input  logic [15:0]            pulse_us,
    input  logic                   last,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     pending,
    output int                     failures,
    output int                     checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  servo;
        logic [15:0] pulse;
        logic        last;
    } pulse_cmd_t;

    pulse_cmd_t           pulse_q [$];
    phase_t               ch_phase [NUM_CHANNELS];
    logic                 ch_full [NUM_CHANNELS];
    logic [ELAPSED_W-1:0] ch_elapsed [NUM_CHANNELS];
    cfg_t                 regs;
    int                   n_fail;
    int                   n_checked;

    always @(posedge clk or negedge rst_n)
    begin
        pulse_cmd_t got;
        pulse_cmd_t want;
        pulse_cmd_t walk [NUM_CHANNELS];
        int         n;
        logic [15:0] limit;

        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                ch_phase[i]   = PH_IDLE;
                ch_full[i]    = 1'b0;
                ch_elapsed[i] = '0;
            end
            regs = {ENGAGE_WAIT_RST, HALF_WAIT_RST, FULL_WAIT_RST,
                    ENGAGE_PULSE_RST, DISPENSE_PULSE_RST, SERVO_MAP_RST};
            pulse_q.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ENGAGE_WAIT:    regs.engage_wait    = cfg_data[15:0];
                    REG_HALF_WAIT:      regs.half_wait      = cfg_data[15:0];
                    REG_FULL_WAIT:      regs.full_wait      = cfg_data[15:0];
                    REG_ENGAGE_PULSE:   regs.engage_pulse   = cfg_data[15:0];
                    REG_DISPENSE_PULSE: regs.dispense_pulse = cfg_data[15:0];
                    REG_SERVO_MAP:      regs.servo_map      = cfg_data;
                    default:            ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                got = {servo_number, pulse_us, last};
                n_checked++;
                if (pulse_q.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("%0t: unexpected pulse command: servo %0d pulse %0d last %0b",
                                 $realtime, got.servo, got.pulse, got.last);
                end
                else
                begin
                    want = pulse_q.pop_front();
                    if (got !== want)
                    begin
                        n_fail++;
                        if (n_fail <= 10)
                        begin
                            $write("%0t: pulse command mismatch: expected servo %0d ",
                                   $realtime, want.servo);
                            $write("pulse %0d last %0b, ", want.pulse, want.last);
                            $display("got servo %0d pulse %0d last %0b",
                                     got.servo, got.pulse, got.last);
                        end
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (cmd == CMD_ACTIVATE)
                begin
                    ch_phase[channel_index]   = PH_ENGAGE;
                    ch_full[channel_index]    = full_dose;
                    ch_elapsed[channel_index] = '0;
                end
                else
                begin
                    n = 0;
                    for (int i = 0; i < NUM_CHANNELS; i++)
                    begin
                        if (ch_phase[i] != PH_IDLE)
                        begin
                            walk[n].servo = regs.servo_map[4 * (i % 8) +: 4];
                            walk[n].pulse = (ch_phase[i] == PH_ENGAGE) ? regs.engage_pulse
                                                                       : regs.dispense_pulse;
                            walk[n].last  = 1'b0;
                            n++;
                            if (ch_elapsed[i] != ELAPSED_MAX)
                                ch_elapsed[i] = ch_elapsed[i] + 1'b1;
                            case (ch_phase[i])
                                PH_ENGAGE: limit = regs.engage_wait;
                                PH_HALF:   limit = regs.half_wait;
                                default:   limit = regs.full_wait;
                            endcase
                            if (ch_elapsed[i] > limit)
                            begin
                                ch_elapsed[i] = '0;
                                if (ch_phase[i] == PH_ENGAGE)
                                begin
                                    ch_phase[i] = ch_full[i] ? PH_FULL : PH_HALF;
                                    ch_full[i]  = 1'b0;
                                end
                                else
                                    ch_phase[i] = PH_IDLE;
                            end
                        end
                    end
                    for (int k = 0; k < n; k++)
                    begin
                        walk[k].last = (k == n - 1);
                        pulse_q.push_back(walk[k]);
                    end
                end
            end
        end

        pending  <= pulse_q.size();
        failures <= n_fail;
        checked  <= n_checked;
    end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the servo dispense sequencer.
// A short directed part checks idle ticks, the reset registers, zero-length
// phases, every channel and the restart of a busy channel. Random activates
// and ticks then run under several register settings, the extremes among
// them, with random command gaps and result stalls in all but the last run.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msds_pkg::*;

    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   cmd;
    logic [2:0]             channel_index;
    logic                   full_dose;
    logic                   out_valid;
    logic                   out_stall;
    logic [3:0]             servo_number;
    logic [15:0]            pulse_us;
    logic                   last;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int   pending;
    int   failures;
    int   checked;
    int   activates;
    int   ticks;
    int   settings;
    int   stuck_cycles;
    logic quiet;

    multi_channel_servo_dispense_sequencer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .channel_index (channel_index),
        .full_dose     (full_dose),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .servo_number  (servo_number),
        .pulse_us      (pulse_us),
        .last          (last),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    msds_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .channel_index (channel_index),
        .full_dose     (full_dose),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .servo_number  (servo_number),
        .pulse_us      (pulse_us),
        .last          (last),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .failures      (failures),
        .checked       (checked)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            stuck_cycles <= 0;
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles.", WATCHDOG_LIMIT);
            $display("tb failed");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!quiet)
            begin
                out_stall <= 1'b1;
                for (int k = $urandom_range(1, 19); k > 0 && !quiet; k--)
                    @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_regs(input logic [15:0] engage_wait, input logic [15:0] half_wait,
                             input logic [15:0] full_wait, input logic [15:0] engage_pulse,
                             input logic [15:0] dispense_pulse, input logic [31:0] servo_map);
        write_reg(REG_ENGAGE_WAIT, {16'h0, engage_wait});
        write_reg(REG_HALF_WAIT, {16'h0, half_wait});
        write_reg(REG_FULL_WAIT, {16'h0, full_wait});
        write_reg(REG_ENGAGE_PULSE, {16'h0, engage_pulse});
        write_reg(REG_DISPENSE_PULSE, {16'h0, dispense_pulse});
        write_reg(REG_SERVO_MAP, servo_map);
        write_reg(REG_UNUSED_LO, $urandom);
        write_reg(REG_UNUSED_HI, $urandom);
        cfg_write <= 1'b0;
        settings++;
    endtask

    task automatic send(input logic op, input logic [2:0] ch, input logic dose);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= op;
        channel_index <= ch;
        full_dose     <= dose;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == CMD_ACTIVATE)
            activates++;
        else
            ticks++;
    endtask

    task automatic wait_results;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic settle;
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int n_items);
        for (int k = 0; k < n_items; k++)
        begin
            if ($urandom_range(0, 24) == 0)
                wait_results();
            if ($urandom_range(0, 9) < 3)
                send(CMD_ACTIVATE, 3'($urandom_range(0, NUM_CHANNELS - 1)),
                     1'($urandom_range(0, 1)));
            else
                send(CMD_TICK, 3'($urandom), 1'($urandom));
        end
        settle();
    endtask

    initial
    begin
        quiet         = 1'b0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        cmd           <= CMD_TICK;
        channel_index <= '0;
        full_dose     <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= REG_ENGAGE_WAIT;
        cfg_data      <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: an idle tick, then two channels engaging.
        send(CMD_TICK, 3'd0, 1'b0);
        send(CMD_ACTIVATE, 3'd0, 1'b0);
        send(CMD_ACTIVATE, 3'd7, 1'b1);
        send(CMD_TICK, 3'd5, 1'b1);
        send(CMD_TICK, 3'd0, 1'b0);
        settle();

        // Zero-length phases, every channel, and a restart of a busy channel.
        load_regs(16'd0, 16'd0, 16'd1, 16'd0, 16'hFFFF, 32'hFEDC_BA98);
        for (int c = 0; c < NUM_CHANNELS; c++)
            send(CMD_ACTIVATE, 3'(c), 1'(c % 2));
        send(CMD_TICK, 3'd0, 1'b0);
        send(CMD_ACTIVATE, 3'd2, 1'b1);
        repeat (4) send(CMD_TICK, 3'd7, 1'b0);
        settle();

        load_regs(16'($urandom_range(0, 6)), 16'($urandom_range(0, 8)),
                  16'($urandom_range(0, 12)), 16'($urandom), 16'($urandom), $urandom);
        run_random(60);

        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0);
        run_random(30);

        load_regs(16'($urandom_range(0, 6)), 16'($urandom_range(0, 8)),
                  16'($urandom_range(0, 12)), 16'($urandom), 16'($urandom), 32'hFFFF_FFFF);
        run_random(60);

        quiet = 1'b1;
        load_regs(16'($urandom_range(0, 4)), 16'($urandom_range(0, 6)),
                  16'($urandom_range(0, 10)), 16'($urandom), 16'($urandom), $urandom);
        run_random(60);

        $display("Run covered %0d activates and %0d ticks under %0d register settings.",
                 activates, ticks, settings + 1);
        $display("%0d pulse commands checked, %0d failures.", checked, failures);
        if (failures == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
